// ===== rtl/cfb_pkg.sv =====
package cfb_pkg;

    localparam int FRAME_LEN   = 11;
    localparam int POS_W       = 4;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [7:0]  SYNC_MARK     = 8'hAA;
    localparam logic [15:0] LEN_FIELD     = 16'd8;
    localparam logic [15:0] CRC_START     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

    // frame offsets
    localparam logic [POS_W-1:0] POS_SYNC   = 4'd0;
    localparam logic [POS_W-1:0] POS_LEN_LO = 4'd1;
    localparam logic [POS_W-1:0] POS_LEN_HI = 4'd2;
    localparam logic [POS_W-1:0] POS_CMD    = 4'd3;
    localparam logic [POS_W-1:0] POS_STAT   = 4'd4;
    localparam logic [POS_W-1:0] POS_VAL0   = 4'd5;
    localparam logic [POS_W-1:0] POS_VAL1   = 4'd6;
    localparam logic [POS_W-1:0] POS_VAL2   = 4'd7;
    localparam logic [POS_W-1:0] POS_VAL3   = 4'd8;
    localparam logic [POS_W-1:0] POS_CRC_LO = 4'd9;
    localparam logic [POS_W-1:0] POS_CRC_HI = 4'd10;

    typedef struct packed {
        logic [7:0]  command;
        logic [7:0]  status_code;
        logic [31:0] payload_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       frame_byte;
        logic [POS_W-1:0] byte_position;
        logic             last_byte;
    } out_item_t;

    // handshake between the request queue and the serialiser
    typedef struct packed {
        logic     valid;
        in_item_t item;
    } queue_head_t;

    // one byte through the reflected crc, bit at a time
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/crc16_frame_builder.sv =====
// channel  | dir | handshake            | payload
// request  | in  | push / full          | in_item_t  (command, status_code, payload_value)
// result   | out | empty / pop          | out_item_t (frame_byte, byte_position, last_byte)
//
// each request gives eleven result bytes, one per cycle while pop keeps the result slot draining
// the next request is loaded on the closing byte, so frames run back to back; crc runs alongside bytes 3 to 8
// a two-entry request queue parts intake from the serialiser; a registered result slot
// holds the current byte until it is popped, and the next byte is loaded as it drains
// reset clears queue pointers, busy flag, byte position and result valid; payload registers keep no reset
// a stalled pop holds the result slot and the serialiser; full rises when the queue is full
module crc16_frame_builder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  cfb_pkg::in_item_t  request,
    output logic               empty,
    input  logic               pop,
    output cfb_pkg::out_item_t result
);
    import cfb_pkg::*;

    queue_head_t head;
    logic        take;

    // front: request intake queue
    cfb_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .head    (head),
        .take    (take)
    );

    // back: frame serialiser with running crc
    cfb_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .take   (take),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // flag marks the crc high byte and nothing else
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.last_byte == (result.byte_position == POS_CRC_HI)))
        else $error("last_byte flag out of step with byte position");

    // sync byte opens every frame
    a_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.byte_position == POS_SYNC) |-> (result.frame_byte == SYNC_MARK))
        else $error("frame does not start with sync");

    // bytes within a frame come in consecutive order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && result.byte_position != POS_CRC_HI) |=>
        (empty || result.byte_position == $past(result.byte_position) + 1'b1))
        else $error("frame byte skipped or repeated");

    // after a frame closes the next byte is a sync byte
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && result.byte_position == POS_CRC_HI) |=>
        (empty || result.byte_position == POS_SYNC))
        else $error("frame did not restart at offset zero");

endmodule

// ===== rtl/cfb_front.sv =====
module cfb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  cfb_pkg::in_item_t request,
    output cfb_pkg::queue_head_t head,
    input  logic              take
);
    import cfb_pkg::*;

    in_item_t            slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_take;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign do_push = push && !full;
    assign do_take = take && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_take)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_take)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_take)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= request;
    end

endmodule

// ===== rtl/cfb_back.sv =====
module cfb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfb_pkg::queue_head_t head,
    output logic                 take,
    output logic                 empty,
    input  logic                 pop,
    output cfb_pkg::out_item_t   result
);
    import cfb_pkg::*;

    in_item_t          cur_reg, cur_next;
    logic              busy_reg, busy_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [15:0]       crc_reg, crc_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;
    logic              advance;
    logic [7:0]        byte_sel;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    // serialiser busy and output slot free or being drained this cycle
    assign advance = busy_reg && (!out_valid_reg || pop);

    always_comb
    begin
        case (pos_reg)
            POS_SYNC:   byte_sel = SYNC_MARK;
            POS_LEN_LO: byte_sel = LEN_FIELD[7:0];
            POS_LEN_HI: byte_sel = LEN_FIELD[15:8];
            POS_CMD:    byte_sel = cur_reg.command;
            POS_STAT:   byte_sel = cur_reg.status_code;
            POS_VAL0:   byte_sel = cur_reg.payload_value[7:0];
            POS_VAL1:   byte_sel = cur_reg.payload_value[15:8];
            POS_VAL2:   byte_sel = cur_reg.payload_value[23:16];
            POS_VAL3:   byte_sel = cur_reg.payload_value[31:24];
            POS_CRC_LO: byte_sel = crc_reg[7:0];
            POS_CRC_HI: byte_sel = crc_reg[15:8];
            default:    byte_sel = 8'h00;
        endcase
    end

    always_comb
    begin
        cur_next       = cur_reg;
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        take           = 1'b0;

        if (pop && out_valid_reg)
            out_valid_next = 1'b0;

        if (advance)
        begin
            out_next.frame_byte    = byte_sel;
            out_next.byte_position = pos_reg;
            out_next.last_byte     = (pos_reg == POS_CRC_HI);
            out_valid_next         = 1'b1;
            if (pos_reg inside {[POS_CMD:POS_VAL3]})
                crc_next = crc_byte(crc_reg, byte_sel);
            pos_next = pos_reg + 1'b1;
        end

        // load the next request when idle or on the closing byte
        if (!busy_reg || (advance && pos_reg == POS_CRC_HI))
        begin
            take      = head.valid;
            busy_next = head.valid;
            cur_next  = head.item;
            pos_next  = POS_SYNC;
            crc_next  = CRC_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= POS_SYNC;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        crc_reg <= crc_next;
        out_reg <= out_next;
    end

endmodule
